@@ rtl/pcc_pkg.sv @@
package pcc_pkg;

   localparam int DW             = 64;
   localparam int FRAC_BITS_DEF  = 32;
   localparam int GM1_W          = 35;
   localparam logic [GM1_W-1:0] GM1_RESET = 35'd1717986918;
   localparam int DIV_STEPS      = 4;
   localparam int DIV_STAGES     = DW / DIV_STEPS;
   localparam int MUL_LAT        = 3;
   localparam int NUM_DIV        = 4;

   localparam logic OP_TO_CONS = 1'b0;
   localparam logic OP_TO_PRIM = 1'b1;

   localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic               opcode;
      logic signed [63:0] density;
      logic signed [63:0] comp_x;
      logic signed [63:0] comp_y;
      logic signed [63:0] comp_z;
      logic signed [63:0] energy_in;
      logic signed [63:0] pressure_in;
   } req_type;

   typedef struct packed {
      logic signed [63:0] out_x;
      logic signed [63:0] out_y;
      logic signed [63:0] out_z;
      logic signed [63:0] energy_out;
      logic signed [63:0] pressure_out;
      logic               zero_density;
      logic               saturated;
   } rsp_type;

   // values riding along the pipeline next to the arithmetic
   typedef struct packed {
      logic          op;
      logic          zero;
      logic          sat;
      logic [DW-1:0] rho;
      logic [DW-1:0] e;
      logic [DW-1:0] p;
      logic [DW-1:0] ox;
      logic [DW-1:0] oy;
      logic [DW-1:0] oz;
      logic [DW-1:0] t;
      logic [DW-1:0] m;
   } side_type;

   typedef struct packed {
      logic [DW-1:0] den;
      logic [DW-1:0] rem;
      logic [DW-1:0] num;
      logic [DW-1:0] quo;
      logic          ovf;
      logic          neg;
   } div_type;

   typedef struct packed {
      logic          sat;
      logic [DW-1:0] val;
   } res_type;

   function automatic logic [DW-1:0] mag(logic [DW-1:0] a);
      return a[DW-1] ? (~a + 1'b1) : a;
   endfunction

   function automatic res_type clip(logic hi_nz, logic [DW-1:0] lo, logic neg);
      res_type r;
      if (!neg) begin
         r.sat = hi_nz | lo[DW-1];
         r.val = r.sat ? Q_MAX : lo;
      end else begin
         r.sat = hi_nz | (lo > Q_MIN);
         r.val = r.sat ? Q_MIN : (~lo + 1'b1);
      end
      return r;
   endfunction

   function automatic res_type sat_add(logic [DW-1:0] a, logic [DW-1:0] b);
      res_type     r;
      logic [DW-1:0] s;
      s     = a + b;
      r.sat = (a[DW-1] == b[DW-1]) && (s[DW-1] != a[DW-1]);
      r.val = r.sat ? (a[DW-1] ? Q_MIN : Q_MAX) : s;
      return r;
   endfunction

   function automatic res_type sat_sub(logic [DW-1:0] a, logic [DW-1:0] b);
      res_type     r;
      logic [DW-1:0] s;
      s     = a - b;
      r.sat = (a[DW-1] != b[DW-1]) && (s[DW-1] != a[DW-1]);
      r.val = r.sat ? (a[DW-1] ? Q_MIN : Q_MAX) : s;
      return r;
   endfunction

   // a few restoring-division steps, one quotient bit each
   function automatic div_type div_steps(div_type d);
      div_type     r;
      logic [DW:0] w;
      r = d;
      for (int k = 0; k < DIV_STEPS; k++) begin
         w     = {r.rem, r.num[DW-1]};
         r.num = {r.num[DW-2:0], 1'b0};
         if (w >= {1'b0, r.den}) begin
            r.rem = DW'(w - {1'b0, r.den});
            r.quo = {r.quo[DW-2:0], 1'b1};
         end else begin
            r.rem = w[DW-1:0];
            r.quo = {r.quo[DW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/pcc_mul.sv @@
module pcc_mul #(
   parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [pcc_pkg::DW-1:0] a,
   input  logic [pcc_pkg::DW-1:0] b,
   output logic [pcc_pkg::DW-1:0] p,
   output logic                   sat
);

   localparam int HW = pcc_pkg::DW / 2;
   localparam int PW = 2 * pcc_pkg::DW;

   logic [pcc_pkg::DW-1:0] ma_ff, mb_ff;
   logic                   neg1_ff, neg2_ff;
   logic [pcc_pkg::DW-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [PW-1:0]          sum_in, q_in;
   pcc_pkg::res_type       res_in, res_ff;

   always_comb begin
      sum_in = {{HW*2{1'b0}}, pp00_ff}
             + ({{HW*2{1'b0}}, pp01_ff} << HW)
             + ({{HW*2{1'b0}}, pp10_ff} << HW)
             + {pp11_ff, {pcc_pkg::DW{1'b0}}};
      q_in   = sum_in >> FRAC_BITS;
      res_in = pcc_pkg::clip(|q_in[PW-1:pcc_pkg::DW], q_in[pcc_pkg::DW-1:0], neg2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= pcc_pkg::mag(a);
         mb_ff   <= pcc_pkg::mag(b);
         neg1_ff <= a[pcc_pkg::DW-1] ^ b[pcc_pkg::DW-1];
         pp00_ff <= pcc_pkg::DW'(ma_ff[HW-1:0] * mb_ff[HW-1:0]);
         pp01_ff <= pcc_pkg::DW'(ma_ff[HW-1:0] * mb_ff[pcc_pkg::DW-1:HW]);
         pp10_ff <= pcc_pkg::DW'(ma_ff[pcc_pkg::DW-1:HW] * mb_ff[HW-1:0]);
         pp11_ff <= pcc_pkg::DW'(ma_ff[pcc_pkg::DW-1:HW] * mb_ff[pcc_pkg::DW-1:HW]);
         neg2_ff <= neg1_ff;
         res_ff  <= res_in;
      end
   end

   assign p   = res_ff.val;
   assign sat = res_ff.sat;

endmodule

@@ rtl/primitive_conservative_converter.sv @@
// Throughput: one beat per cycle while no rsp beat is held; the 16-stage
// divider and the 3-stage multipliers at three points along the pipe are
// fully pipelined.
// A held rsp beat freezes the whole pipeline and raises req_stall.
// Synchronous reset clears every valid bit and loads gamma_minus_one with 0.4.
module primitive_conservative_converter #(
   parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pcc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pcc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pcc_pkg::GM1_W-1:0] csr_data
);

   localparam int DW  = pcc_pkg::DW;
   localparam int DS  = pcc_pkg::DIV_STAGES;
   localparam int ML  = pcc_pkg::MUL_LAT;
   localparam int ND  = pcc_pkg::NUM_DIV;
   localparam int LAT = 1 + DS + 1 + ML + 3 + ML + 1 + ML + 1;
   localparam int GSH_L = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
   localparam int GSH_R = (FRAC_BITS >= 32) ? 0 : 32 - FRAC_BITS;

   logic                      adv, req_accept;
   logic [LAT-1:0]            vld_ff, vld_in;
   logic [pcc_pkg::GM1_W-1:0] gm1_ff;
   logic [DW-1:0]             gm1_al;

   pcc_pkg::side_type in_ff, in_in;
   pcc_pkg::div_type  dv_ff [DS][ND];
   pcc_pkg::div_type  dv_in [DS][ND];
   pcc_pkg::side_type ds_ff [DS];
   pcc_pkg::side_type vel_ff, vel_in;
   pcc_pkg::side_type m1_ff [ML];
   pcc_pkg::side_type a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic [DW-1:0]     a1_s_ff, a1_z_ff, a2_h_ff;
   logic [DW-1:0]     a2_h_in;
   pcc_pkg::side_type m2_ff [ML];
   pcc_pkg::side_type pm_ff, pm_in;
   pcc_pkg::side_type m3_ff [ML];
   pcc_pkg::rsp_type  out_ff, out_in;

   logic [DW-1:0] sq_p [3];
   logic          sq_s [3];
   logic [DW-1:0] mo_p [3];
   logic          mo_s [3];
   logic [DW-1:0] e_p, g_p;
   logic          e_s, g_s;

   assign adv        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;
   assign vld_in     = {vld_ff[LAT-2:0], req_accept};
   assign rsp_valid  = vld_ff[LAT-1];
   assign rsp_data   = out_ff;
   assign csr_ready  = 1'b1;
   assign gm1_al     = (DW'(gm1_ff) << GSH_L) >> GSH_R;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         gm1_ff <= pcc_pkg::GM1_RESET;
      end else begin
         if (csr_valid) begin
            gm1_ff <= csr_data;
         end
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
   end

   // capture
   always_comb begin
      in_in      = '0;
      in_in.op   = req_data.opcode;
      in_in.rho  = req_data.density;
      in_in.ox   = req_data.comp_x;
      in_in.oy   = req_data.comp_y;
      in_in.oz   = req_data.comp_z;
      in_in.e    = req_data.energy_in;
      in_in.p    = req_data.pressure_in;
      in_in.zero = (req_data.opcode == pcc_pkg::OP_TO_PRIM) && (req_data.density == '0);
   end

   // divider: the first stage also loads the numerators
   always_comb begin
      logic [DW-1:0]    src [ND];
      logic [DW-1:0]    ua, ub, hi;
      pcc_pkg::div_type d;
      src[0] = in_ff.ox;
      src[1] = in_ff.oy;
      src[2] = in_ff.oz;
      src[3] = in_ff.e;
      ub     = pcc_pkg::mag(in_ff.rho);
      for (int i = 0; i < ND; i++) begin
         ua    = pcc_pkg::mag(src[i]);
         hi    = ua >> (DW - FRAC_BITS);
         d.den = ub;
         d.rem = hi;
         d.num = ua << FRAC_BITS;
         d.quo = '0;
         d.ovf = (hi >= ub);
         d.neg = src[i][DW-1] ^ in_ff.rho[DW-1];
         dv_in[0][i] = pcc_pkg::div_steps(d);
      end
      for (int k = 1; k < DS; k++) begin
         for (int i = 0; i < ND; i++) begin
            dv_in[k][i] = pcc_pkg::div_steps(dv_ff[k-1][i]);
         end
      end
   end

   // pick velocities: inputs for op 0, clipped quotients for op 1, zeros for op 1 with zero density
   always_comb begin
      pcc_pkg::res_type r [ND];
      for (int i = 0; i < ND; i++) begin
         r[i] = pcc_pkg::clip(dv_ff[DS-1][i].ovf, dv_ff[DS-1][i].quo, dv_ff[DS-1][i].neg);
      end
      vel_in = ds_ff[DS-1];
      if (vel_in.op == pcc_pkg::OP_TO_PRIM) begin
         if (vel_in.zero) begin
            vel_in.ox = '0;
            vel_in.oy = '0;
            vel_in.oz = '0;
            vel_in.t  = '0;
         end else begin
            vel_in.ox  = r[0].val;
            vel_in.oy  = r[1].val;
            vel_in.oz  = r[2].val;
            vel_in.t   = r[3].val;
            vel_in.sat = r[0].sat | r[1].sat | r[2].sat | r[3].sat;
         end
      end
   end

   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_x (.clock, .en(adv), .a(vel_ff.ox), .b(vel_ff.ox),
                                            .p(sq_p[0]), .sat(sq_s[0]));
   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_y (.clock, .en(adv), .a(vel_ff.oy), .b(vel_ff.oy),
                                            .p(sq_p[1]), .sat(sq_s[1]));
   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_sq_z (.clock, .en(adv), .a(vel_ff.oz), .b(vel_ff.oz),
                                            .p(sq_p[2]), .sat(sq_s[2]));
   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_mo_x (.clock, .en(adv), .a(vel_ff.ox), .b(vel_ff.rho),
                                            .p(mo_p[0]), .sat(mo_s[0]));
   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_mo_y (.clock, .en(adv), .a(vel_ff.oy), .b(vel_ff.rho),
                                            .p(mo_p[1]), .sat(mo_s[1]));
   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_mo_z (.clock, .en(adv), .a(vel_ff.oz), .b(vel_ff.rho),
                                            .p(mo_p[2]), .sat(mo_s[2]));

   // first partial sum of squares; momentum replaces velocity for op 0
   pcc_pkg::res_type s1;
   always_comb begin
      s1     = pcc_pkg::sat_add(sq_p[0], sq_p[1]);
      a1_in  = m1_ff[ML-1];
      a1_in.sat = a1_in.sat | sq_s[0] | sq_s[1] | sq_s[2] | s1.sat;
      if (a1_in.op == pcc_pkg::OP_TO_CONS) begin
         a1_in.ox  = mo_p[0];
         a1_in.oy  = mo_p[1];
         a1_in.oz  = mo_p[2];
         a1_in.sat = a1_in.sat | mo_s[0] | mo_s[1] | mo_s[2];
      end
   end

   pcc_pkg::res_type s2;
   always_comb begin
      s2        = pcc_pkg::sat_add(a1_s_ff, a1_z_ff);
      a2_in     = a1_ff;
      a2_in.sat = a1_ff.sat | s2.sat;
      a2_h_in   = {1'b0, s2.val[DW-1:1]};
   end

   pcc_pkg::res_type s3;
   always_comb begin
      a3_in = a2_ff;
      if (a3_in.op == pcc_pkg::OP_TO_CONS) begin
         s3 = pcc_pkg::sat_add(a2_h_ff, a3_in.e);
      end else begin
         s3 = pcc_pkg::sat_sub(a3_in.t, a2_h_ff);
      end
      a3_in.t   = s3.val;
      a3_in.sat = a3_in.sat | s3.sat;
   end

   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (.clock, .en(adv), .a(a3_ff.rho), .b(a3_ff.t),
                                             .p(e_p), .sat(e_s));

   always_comb begin
      pm_in     = m2_ff[ML-1];
      pm_in.sat = pm_in.sat | e_s;
      if (pm_in.op == pcc_pkg::OP_TO_CONS) begin
         pm_in.t = e_p;
      end else begin
         pm_in.m = e_p;
      end
   end

   pcc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_g (.clock, .en(adv), .a(pm_ff.m), .b(gm1_al),
                                             .p(g_p), .sat(g_s));

   always_comb begin
      pcc_pkg::side_type s;
      s = m3_ff[ML-1];
      if (s.op == pcc_pkg::OP_TO_PRIM) begin
         s.p   = g_p;
         s.sat = s.sat | g_s;
      end
      out_in.out_x        = s.ox;
      out_in.out_y        = s.oy;
      out_in.out_z        = s.oz;
      out_in.energy_out   = s.t;
      out_in.pressure_out = s.p;
      out_in.zero_density = s.zero;
      out_in.saturated    = s.sat;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= in_in;
         dv_ff <= dv_in;
         ds_ff[0] <= in_ff;
         for (int k = 1; k < DS; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
         vel_ff   <= vel_in;
         m1_ff[0] <= vel_ff;
         m2_ff[0] <= a3_ff;
         m3_ff[0] <= pm_ff;
         for (int j = 1; j < ML; j++) begin
            m1_ff[j] <= m1_ff[j-1];
            m2_ff[j] <= m2_ff[j-1];
            m3_ff[j] <= m3_ff[j-1];
         end
         a1_ff     <= a1_in;
         a1_s_ff   <= s1.val;
         a1_z_ff   <= sq_p[2];
         a2_ff     <= a2_in;
         a2_h_ff   <= a2_h_in;
         a3_ff     <= a3_in;
         pm_ff     <= pm_in;
         out_ff    <= out_in;
      end
   end

endmodule

@@ rtl/pcc_checker.sv @@
module pcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pcc_pkg::rsp_type rsp_data
);

   // a held beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // the input side stalls only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a blocked rsp");

   // zero density forces every value to zero
   a_zero_rho: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_density |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0 &&
         rsp_data.energy_out == '0 && rsp_data.pressure_out == '0)
      else $error("zero density result not cleared");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind primitive_conservative_converter pcc_checker u_pcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/sv/primitive_conservative_converter_test.sv @@
module primitive_conservative_converter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 32;
   localparam int IDLE_MAX  = 5000;
   localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ONE   = 64'sh1_0000_0000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   pcc_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   pcc_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [pcc_pkg::GM1_W-1:0] csr_data;

   logic [pcc_pkg::GM1_W-1:0] gm1_shadow;
   pcc_pkg::rsp_type cell_queue[$];
   int mismatches;
   int idle_cycles;
   bit quiet_mode;
   bit hold_rsp;
   bit timed_out;

   primitive_conservative_converter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- fixed-point predictor ----------------
   function automatic logic signed [63:0] clip_wide(logic [127:0] m, bit neg, ref bit sat);
      if (!neg) begin
         if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
            sat = 1;
            return S_MAX;
         end
         return m[63:0];
      end
      if (m > 128'h8000_0000_0000_0000) begin
         sat = 1;
         return S_MIN;
      end
      return -m[63:0];
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
      logic [127:0] p;
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      return clip_wide(p >> 32, (a < 0) != (b < 0), sat);
   endfunction

   function automatic logic signed [63:0] fx_div(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
      logic [127:0] n;
      n = {64'd0, abs64(a)} << 32;
      return clip_wide(n / {64'd0, abs64(b)}, (a < 0) != (b < 0), sat);
   endfunction

   function automatic logic signed [63:0] fx_add(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
      logic signed [64:0] s;
      s = a + b;
      if (s > S_MAX) begin sat = 1; return S_MAX; end
      if (s < S_MIN) begin sat = 1; return S_MIN; end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] fx_sub(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
      logic signed [64:0] s;
      s = a - b;
      if (s > S_MAX) begin sat = 1; return S_MAX; end
      if (s < S_MIN) begin sat = 1; return S_MIN; end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] half_speed2(logic signed [63:0] x,
      logic signed [63:0] y, logic signed [63:0] z, ref bit sat);
      logic signed [63:0] s;
      s = fx_add(fx_mul(x, x, sat), fx_mul(y, y, sat), sat);
      s = fx_add(s, fx_mul(z, z, sat), sat);
      return s >>> 1;
   endfunction

   function automatic pcc_pkg::rsp_type convert_cell(pcc_pkg::req_type c);
      pcc_pkg::rsp_type r;
      bit sat;
      logic signed [63:0] t, eq;
      sat = 0;
      r = '0;
      if (c.opcode == pcc_pkg::OP_TO_CONS) begin
         t = fx_add(half_speed2(c.comp_x, c.comp_y, c.comp_z, sat), c.energy_in, sat);
         r.energy_out = fx_mul(c.density, t, sat);
         r.out_x = fx_mul(c.comp_x, c.density, sat);
         r.out_y = fx_mul(c.comp_y, c.density, sat);
         r.out_z = fx_mul(c.comp_z, c.density, sat);
         r.pressure_out = c.pressure_in;
      end else begin
         if (c.density == 0) begin
            r.zero_density = 1'b1;
            eq = 0;
         end else begin
            r.out_x = fx_div(c.comp_x, c.density, sat);
            r.out_y = fx_div(c.comp_y, c.density, sat);
            r.out_z = fx_div(c.comp_z, c.density, sat);
            eq = fx_div(c.energy_in, c.density, sat);
         end
         r.energy_out = fx_sub(eq, half_speed2(r.out_x, r.out_y, r.out_z, sat), sat);
         r.pressure_out = fx_mul(fx_mul(r.energy_out, c.density, sat),
                                 $signed({29'd0, gm1_shadow}), sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      pcc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", rsp_data);
         end else begin
            want = cell_queue.pop_front();
            if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                rsp_data.out_z !== want.out_z || rsp_data.energy_out !== want.energy_out ||
                rsp_data.pressure_out !== want.pressure_out ||
                rsp_data.zero_density !== want.zero_density ||
                rsp_data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%h y=%h z=%h e=%h p=%h zd=%b s=%b\n",
                           want.out_x, want.out_y, want.out_z, want.energy_out,
                           want.pressure_out, want.zero_density, want.saturated,
                           "         actual   x=%h y=%h z=%h e=%h p=%h zd=%b s=%b",
                           rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                           rsp_data.energy_out, rsp_data.pressure_out,
                           rsp_data.zero_density, rsp_data.saturated);
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_rsp) rsp_stall <= 1'b1;
      else if (quiet_mode) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 13);
   end

   // watchdog on accepted beats
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!hold_rsp)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX && !timed_out) begin
         timed_out = 1;
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_cell(pcc_pkg::req_type c);
      if (!quiet_mode) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cell_queue.push_back(convert_cell(c));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (cell_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_gamma(logic [pcc_pkg::GM1_W-1:0] g);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gm1_shadow = g;
   endtask

   function automatic logic signed [63:0] rand_value();
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return $signed({$urandom_range(7), $urandom}) - $signed(64'sh4_0000_0000);
         2: return $signed({32'd0, $urandom}) * ($urandom_range(1) ? 1 : -1);
         3: return ($urandom_range(1) ? S_MAX : S_MIN) + $signed(64'($urandom_range(3)));
         4: return $signed(64'($urandom_range(3))) - 1;
         default: return $signed({16'd0, 16'($urandom_range(65535)), $urandom}) >>> 8;
      endcase
   endfunction

   function automatic pcc_pkg::req_type rand_cell();
      pcc_pkg::req_type c;
      c.opcode = 1'($urandom_range(1));
      c.density = ($urandom_range(19) == 0) ? 64'sd0 : rand_value();
      c.comp_x = rand_value();
      c.comp_y = rand_value();
      c.comp_z = rand_value();
      c.energy_in = rand_value();
      c.pressure_in = rand_value();
      return c;
   endfunction

   function automatic pcc_pkg::req_type make_cell(logic op, logic signed [63:0] rho,
      logic signed [63:0] v, logic signed [63:0] e);
      pcc_pkg::req_type c;
      c.opcode = op;
      c.density = rho;
      c.comp_x = v;
      c.comp_y = -v;
      c.comp_z = v >>> 1;
      c.energy_in = e;
      c.pressure_in = e ^ rho;
      return c;
   endfunction

   task automatic test_directed;
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, ONE, ONE, ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, ONE, ONE, ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, 64'sd0, ONE, ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, 64'sd0, ONE, ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, S_MAX, S_MAX, S_MAX));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, S_MIN, S_MIN, S_MIN));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, S_MAX, S_MIN, S_MAX));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, S_MIN, S_MIN, S_MIN));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, 64'sd1, S_MAX, ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, -64'sd1, ONE, -ONE));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, -ONE, -64'sd1, S_MAX));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, ONE * 3, ONE * 7, ONE * 100));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, 64'sd0, 64'sd0, 64'sd0));
      send_cell(make_cell(pcc_pkg::OP_TO_PRIM, 64'sh7FFF_FFFF, 64'sd0, -64'sd1));
      send_cell(make_cell(pcc_pkg::OP_TO_CONS, 64'sh1234_5678_9ABC_DEF0, -ONE, 64'sd5));
   endtask

   task automatic test_random(int n);
      repeat (n) send_cell(rand_cell());
   endtask

   task automatic test_backpressure;
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         test_random(100);
      join
   endtask

   task automatic test_gamma_sweep;
      logic [pcc_pkg::GM1_W-1:0] g;
      g = '0;
      write_gamma(g);
      test_random(150);
      write_gamma({pcc_pkg::GM1_W{1'b1}});
      test_random(150);
      write_gamma(35'h4_0000_0000);
      test_random(150);
      g = {3'($urandom_range(7)), $urandom};
      write_gamma(g);
      test_random(150);
      write_gamma(pcc_pkg::GM1_RESET);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      gm1_shadow = pcc_pkg::GM1_RESET;
      mismatches = 0;
      idle_cycles = 0;
      quiet_mode = 0;
      hold_rsp = 0;
      timed_out = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(500);
      // run without idling on either side
      quiet_mode = 1;
      test_random(400);
      quiet_mode = 0;
      test_backpressure();
      test_gamma_sweep();
      test_random(200);

      drain();
      if (mismatches == 0 && cell_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
